>>> src/fca_pkg.sv
// Shared constants, codes and types of the free-cluster accounting block.
package fca_pkg;

    // Bits per byte; stream data is padded to whole bytes.
    localparam int NBBY = 8;

    localparam int BITMAP_BLOCKS_DEF = 4096;
    localparam int MAX_SUMMARY_DEF   = 16;

    localparam int SIZE_W  = 5;
    localparam int COUNT_W = 13;
    localparam int BLOCK_W = 12;
    localparam int RUN_W   = 5;
    localparam int HCNT_W  = 32;

    localparam int S_TDATA_W = ((BLOCK_W + NBBY - 1) / NBBY) * NBBY;
    localparam int M_TDATA_W = ((4 * RUN_W + NBBY - 1) / NBBY) * NBBY;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);

    typedef enum logic {
        CFG_SUMMARY_SIZE        = 1'b0,
        CFG_CLUSTER_BLOCK_COUNT = 1'b1
    } t_cfg_index;

    typedef enum logic {
        KIND_FREE  = 1'b0,
        KIND_ALLOC = 1'b1
    } t_kind;

    typedef struct packed {
        logic               kind;
        logic [BLOCK_W-1:0] block;
        logic [SIZE_W-1:0]  size;
        logic [COUNT_W-1:0] count;
        logic               disabled;
        logic               oor;
    } t_req;

    // Packed so that forward_run lands in the lowest bits.
    typedef struct packed {
        logic [RUN_W-1:0] largest_class;
        logic [RUN_W-1:0] merged_class;
        logic [RUN_W-1:0] backward_run;
        logic [RUN_W-1:0] forward_run;
    } t_result;

endpackage

>>> src/free_cluster_accounting.sv
// Top level of the free-cluster accounting block.
// Each request frees or allocates one block of the free-block bitmap and
// yields one result with the free runs after and before the block, the
// histogram class adjusted for the merged run and the largest class with a
// nonzero count. Requests are handled one at a time by the back part: a
// request that changes state goes through its single bitmap memory port
// (three row reads and one row write-back), window extraction, run counting
// and merging, up to three histogram read-modify-writes and a final step that
// hands off the result. A request that is out of range, or arrives while the
// summary size is zero, goes straight to that final step. A two-entry queue
// lets new requests be taken while one is in work, and the result register
// lets the next request start while a result still waits. After reset the
// bitmap is cleared one row per cycle, a row being MAX_SUMMARY bits rounded
// up to a power of two; no request is taken during that pass, while
// configuration writes are.
module free_cluster_accounting #(
    parameter int BITMAP_BLOCKS = fca_pkg::BITMAP_BLOCKS_DEF,
    parameter int MAX_SUMMARY   = fca_pkg::MAX_SUMMARY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_index,
    input  logic [fca_pkg::COUNT_W-1:0]    i_cfg_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // block_number[11:0], zero padding above.
    input  logic [fca_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // kind.
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // forward_run[4:0], backward_run[9:5], merged_class[14:10],
    // largest_class[19:15], zero padding above.
    output logic [fca_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // out_of_range.
    output logic                           o_m_tuser
);
    import fca_pkg::*;

    t_req q_in;
    t_req q_head;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    logic clear_done;

    fca_front #(
        .BITMAP_BLOCKS(BITMAP_BLOCKS),
        .MAX_SUMMARY  (MAX_SUMMARY)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_q_full    (q_full),
        .i_clear_done(clear_done),
        .o_push      (q_push),
        .o_req       (q_in)
    );

    fca_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_req  (q_in),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_head (q_head)
    );

    fca_back #(
        .BITMAP_BLOCKS(BITMAP_BLOCKS),
        .MAX_SUMMARY  (MAX_SUMMARY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_clear_done(clear_done),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

>>> src/fca_front.sv
// Front part: configuration registers, request intake and classification.
module fca_front #(
    parameter int BITMAP_BLOCKS = fca_pkg::BITMAP_BLOCKS_DEF,
    parameter int MAX_SUMMARY   = fca_pkg::MAX_SUMMARY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_index,
    input  logic [fca_pkg::COUNT_W-1:0]    i_cfg_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [fca_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_q_full,
    input  logic                           i_clear_done,
    output logic                           o_push,
    output fca_pkg::t_req                  o_req
);
    import fca_pkg::*;

    logic [SIZE_W-1:0]  r_summary_size;
    logic [COUNT_W-1:0] r_cluster_block_count;
    logic [SIZE_W-1:0]  size_eff;
    logic [COUNT_W-1:0] count_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_summary_size        <= '0;
            r_cluster_block_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SUMMARY_SIZE:        r_summary_size        <= i_cfg_data[SIZE_W-1:0];
                CFG_CLUSTER_BLOCK_COUNT: r_cluster_block_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (int'(r_summary_size) > MAX_SUMMARY) begin
            size_eff = SIZE_W'(MAX_SUMMARY);
        end else begin
            size_eff = r_summary_size;
        end
        if (int'(r_cluster_block_count) > BITMAP_BLOCKS) begin
            count_eff = COUNT_W'(BITMAP_BLOCKS);
        end else begin
            count_eff = r_cluster_block_count;
        end
        o_req.kind     = i_s_tuser;
        o_req.block    = i_s_tdata[BLOCK_W-1:0];
        o_req.size     = size_eff;
        o_req.count    = count_eff;
        o_req.disabled = (size_eff == '0);
        o_req.oor      = (size_eff != '0) &&
                         (COUNT_W'(i_s_tdata[BLOCK_W-1:0]) >= count_eff);
    end

    assign o_s_tready = !i_q_full && i_clear_done;
    assign o_push     = i_s_tvalid && o_s_tready;

endmodule

>>> src/fca_queue.sv
// Short request queue between the front and back parts.
module fca_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fca_pkg::t_req i_req,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output fca_pkg::t_req o_head
);
    import fca_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_req             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> src/fca_back.sv
// Back part: bitmap update, run measurement, histogram update and result register.
module fca_back #(
    parameter int BITMAP_BLOCKS = fca_pkg::BITMAP_BLOCKS_DEF,
    parameter int MAX_SUMMARY   = fca_pkg::MAX_SUMMARY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_empty,
    input  fca_pkg::t_req                  i_head,
    output logic                           o_pop,
    output logic                           o_clear_done,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [fca_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                           o_m_tuser
);
    import fca_pkg::*;

    localparam int LOG_R    = $clog2(MAX_SUMMARY);
    localparam int ROW_BITS = 1 << LOG_R;
    localparam int ROWS     = (BITMAP_BLOCKS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WIN_W    = 3 * ROW_BITS;
    localparam int SH_W     = $clog2(WIN_W + 1);
    localparam int HDEPTH   = MAX_SUMMARY + 1;
    localparam int HAW      = $clog2(HDEPTH);
    localparam int CNT_W    = $clog2(MAX_SUMMARY + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_PREV, S_RD_CUR, S_RD_NEXT, S_WRITE,
        S_EXTRACT, S_COUNT, S_MERGE, S_HRD, S_HWR, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_MERGED, OP_BACK, OP_FORW
    } t_op;

    // Memories.
    logic [ROW_BITS-1:0] r_bitmap [ROWS];
    logic [ROW_BITS-1:0] r_bm_q;
    logic [HCNT_W-1:0]   r_hist [HDEPTH];
    logic [HCNT_W-1:0]   r_h_q;

    // Control and payload registers.
    t_state              r_state;
    t_op                 r_op;
    logic [ROW_AW-1:0]   r_clr_addr;
    logic [HDEPTH-1:0]   r_hvalid;
    logic [HDEPTH-1:0]   r_nz;
    t_req                r_req;
    logic [ROW_BITS-1:0] r_row_prev;
    logic [ROW_BITS-1:0] r_row_cur;
    logic [ROW_BITS-1:0] r_row_next;
    logic [MAX_SUMMARY-1:0] r_fwd_bits;
    logic [MAX_SUMMARY-1:0] r_bck_bits;
    logic [CNT_W-1:0]    r_forw;
    logic [CNT_W-1:0]    r_back;
    logic [RUN_W-1:0]    r_merged;
    logic [HAW-1:0]      r_h_addr;
    logic                r_o_valid;
    t_result             r_o_res;
    logic                r_o_oor;

    // Combinational signals.
    logic [ROW_AW-1:0]   cur_row;
    logic [ROW_AW-1:0]   prev_row;
    logic [ROW_AW-1:0]   next_row;
    logic [BLOCK_W-1:0]  off;
    logic [ROW_BITS-1:0] bit_mask;
    logic [ROW_BITS-1:0] cur_mod;
    logic [WIN_W-1:0]    win;
    logic [WIN_W-1:0]    win_rev;
    logic [SH_W-1:0]     fwd_sh;
    logic [SH_W-1:0]     bck_sh;
    logic [COUNT_W-1:0]  fwd_lim;
    logic [CNT_W-1:0]    n_forw;
    logic [CNT_W-1:0]    n_back;
    logic                fwd_run;
    logic                bck_run;
    logic [CNT_W:0]      sum;
    logic [RUN_W-1:0]    n_merged;
    logic [HAW-1:0]      op_addr;
    logic                op_en;
    logic                op_inc;
    logic [HCNT_W-1:0]   h_old;
    logic [HCNT_W-1:0]   h_new;
    logic [RUN_W-1:0]    largest;
    logic                bm_we;
    logic [ROW_AW-1:0]   bm_waddr;
    logic [ROW_BITS-1:0] bm_wdata;
    logic [ROW_AW-1:0]   bm_raddr;
    logic                h_we;
    logic                out_free;

    assign out_free = !r_o_valid || i_m_tready;

    always_comb begin
        cur_row  = ROW_AW'(r_req.block >> LOG_R);
        prev_row = (cur_row == '0) ? cur_row : cur_row - 1'b1;
        next_row = (cur_row == ROW_AW'(ROWS - 1)) ? cur_row : cur_row + 1'b1;
        off      = r_req.block & BLOCK_W'(ROW_BITS - 1);
        bit_mask = ROW_BITS'(1) << off;
        if (r_req.kind == KIND_FREE) begin
            cur_mod = r_bm_q | bit_mask;
        end else begin
            cur_mod = r_bm_q & ~bit_mask;
        end

        win = {r_row_next, r_row_cur, r_row_prev};
        for (int k = 0; k < WIN_W; k++) begin
            win_rev[k] = win[WIN_W - 1 - k];
        end
        fwd_sh = SH_W'(ROW_BITS + 1) + SH_W'(off);
        bck_sh = SH_W'(2 * ROW_BITS) - SH_W'(off);

        fwd_lim = r_req.count - COUNT_W'(r_req.block) - 1'b1;
        n_forw  = '0;
        n_back  = '0;
        fwd_run = 1'b1;
        bck_run = 1'b1;
        for (int j = 0; j < MAX_SUMMARY; j++) begin
            if (fwd_run && r_fwd_bits[j] && (j < int'(r_req.size)) && (j < int'(fwd_lim))) begin
                n_forw = n_forw + 1'b1;
            end else begin
                fwd_run = 1'b0;
            end
            if (bck_run && r_bck_bits[j] && (j < int'(r_req.size)) && (j < int'(r_req.block))) begin
                n_back = n_back + 1'b1;
            end else begin
                bck_run = 1'b0;
            end
        end

        sum = (CNT_W + 1)'(r_back) + (CNT_W + 1)'(r_forw) + 1'b1;
        if (sum > (CNT_W + 1)'(r_req.size)) begin
            n_merged = r_req.size;
        end else begin
            n_merged = RUN_W'(sum);
        end

        case (r_op)
            OP_MERGED: begin
                op_addr = HAW'(r_merged);
                op_en   = 1'b1;
                op_inc  = (r_req.kind == KIND_FREE);
            end
            OP_BACK: begin
                op_addr = HAW'(r_back);
                op_en   = (r_back != '0);
                op_inc  = (r_req.kind == KIND_ALLOC);
            end
            OP_FORW: begin
                op_addr = HAW'(r_forw);
                op_en   = (r_forw != '0);
                op_inc  = (r_req.kind == KIND_ALLOC);
            end
            default: begin
                op_addr = '0;
                op_en   = 1'b0;
                op_inc  = 1'b0;
            end
        endcase

        h_old = r_hvalid[r_h_addr] ? r_h_q : '0;
        h_new = op_inc ? h_old + 1'b1 : h_old - 1'b1;

        largest = '0;
        for (int c = 1; c <= MAX_SUMMARY; c++) begin
            if (r_nz[c] && (c <= int'(r_req.size))) begin
                largest = RUN_W'(c);
            end
        end
        if (r_req.disabled) begin
            largest = '0;
        end

        bm_we    = 1'b0;
        bm_waddr = cur_row;
        bm_wdata = r_row_cur;
        bm_raddr = cur_row;
        case (r_state)
            S_CLEAR: begin
                bm_we    = 1'b1;
                bm_waddr = r_clr_addr;
                bm_wdata = '0;
            end
            S_RD_PREV: bm_raddr = prev_row;
            S_RD_NEXT: bm_raddr = next_row;
            S_WRITE:   bm_we    = 1'b1;
            default: ;
        endcase
        h_we = (r_state == S_HWR);
    end

    assign o_pop        = (r_state == S_IDLE) && !i_q_empty;
    assign o_clear_done = (r_state != S_CLEAR);

    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            r_bitmap[bm_waddr] <= bm_wdata;
        end
        r_bm_q <= r_bitmap[bm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_hist[r_h_addr] <= h_new;
        end
        r_h_q <= r_hist[op_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_op       <= OP_MERGED;
            r_clr_addr <= '0;
            r_hvalid   <= '0;
            r_nz       <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_o_valid && i_m_tready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ROW_AW'(ROWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_forw   <= '0;
                    r_back   <= '0;
                    r_merged <= '0;
                    if (!i_q_empty) begin
                        r_req <= i_head;
                        if (i_head.disabled || i_head.oor) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RD_PREV;
                        end
                    end
                end
                S_RD_PREV: r_state <= S_RD_CUR;
                S_RD_CUR: begin
                    r_row_prev <= r_bm_q;
                    r_state    <= S_RD_NEXT;
                end
                S_RD_NEXT: begin
                    r_row_cur <= cur_mod;
                    r_state   <= S_WRITE;
                end
                S_WRITE: begin
                    r_row_next <= r_bm_q;
                    r_state    <= S_EXTRACT;
                end
                S_EXTRACT: begin
                    r_fwd_bits <= MAX_SUMMARY'(win >> fwd_sh);
                    r_bck_bits <= MAX_SUMMARY'(win_rev >> bck_sh);
                    r_state    <= S_COUNT;
                end
                S_COUNT: begin
                    r_forw  <= n_forw;
                    r_back  <= n_back;
                    r_state <= S_MERGE;
                end
                S_MERGE: begin
                    r_merged <= n_merged;
                    r_op     <= OP_MERGED;
                    r_state  <= S_HRD;
                end
                S_HRD: begin
                    r_h_addr <= op_addr;
                    if (op_en) begin
                        r_state <= S_HWR;
                    end else if (r_op == OP_FORW) begin
                        r_state <= S_DONE;
                    end else begin
                        r_op <= (r_op == OP_MERGED) ? OP_BACK : OP_FORW;
                    end
                end
                S_HWR: begin
                    r_hvalid[r_h_addr] <= 1'b1;
                    r_nz[r_h_addr]     <= (h_new != '0);
                    if (r_op == OP_FORW) begin
                        r_state <= S_DONE;
                    end else begin
                        r_op    <= (r_op == OP_MERGED) ? OP_BACK : OP_FORW;
                        r_state <= S_HRD;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_valid               <= 1'b1;
                        r_o_res.forward_run     <= RUN_W'(r_forw);
                        r_o_res.backward_run    <= RUN_W'(r_back);
                        r_o_res.merged_class    <= r_merged;
                        r_o_res.largest_class   <= largest;
                        r_o_oor                 <= r_req.oor;
                        r_state                 <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = M_TDATA_W'(r_o_res);
    assign o_m_tuser  = r_o_oor;

endmodule

>>> src/fca_checker.sv
// Port-level assertions for the free-cluster accounting block and their binding.
module fca_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [fca_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input logic                           o_m_tuser
);
    import fca_pkg::*;

    // A result waiting for the consumer keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // An out-of-range request reports no runs and no merged class.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[3*RUN_W-1:0] == '0)
        else $error("out-of-range result carries run data");

    // The merged class covers both runs.
    a_merged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            (o_m_tdata[3*RUN_W-1:2*RUN_W] >= o_m_tdata[RUN_W-1:0]) &&
            (o_m_tdata[3*RUN_W-1:2*RUN_W] >= o_m_tdata[2*RUN_W-1:RUN_W]))
        else $error("merged class below a run length");

    // Right after reset the bitmap is being cleared and nothing is shown.
    a_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_s_tready && !o_m_tvalid)
        else $error("activity right after reset");

endmodule

bind free_cluster_accounting fca_checker u_fca_checker (.*);

>>> sim/cluster_accounting_checker.sv
// Checker that predicts and compares every result of the free-cluster accounting block.
module cluster_accounting_checker
    import fca_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [COUNT_W-1:0]   i_cfg_data,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    // block_number[11:0], zero padding above.
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // kind.
    input  logic                 i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // forward_run[4:0], backward_run[9:5], merged_class[14:10],
    // largest_class[19:15], zero padding above.
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    // out_of_range.
    input  logic                 i_m_tuser,
    output int                   o_pending,
    output int                   o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_result res;
        logic    oor;
    } t_outcome;

    logic [SIZE_W-1:0]  summary_reg;
    logic [COUNT_W-1:0] count_reg;
    bit                 free_map [BITMAP_BLOCKS_DEF];
    logic [HCNT_W-1:0]  run_count [MAX_SUMMARY_DEF + 1];
    t_outcome           expected_results [$];

    function automatic t_outcome account_request(input logic kind,
                                                 input logic [BLOCK_W-1:0] blk);
        t_outcome o;
        int size, limit, stop, fwd, back, merged, i, c;
        o = '0;
        size  = (summary_reg > MAX_SUMMARY_DEF) ? MAX_SUMMARY_DEF : summary_reg;
        limit = (count_reg > BITMAP_BLOCKS_DEF) ? BITMAP_BLOCKS_DEF : count_reg;
        if (size == 0) begin
            return o;
        end
        if (blk >= limit) begin
            o.oor = 1'b1;
        end else begin
            free_map[blk] = (kind == KIND_FREE);
            fwd  = 0;
            back = 0;
            stop = blk + 1 + size;
            if (stop > limit) begin
                stop = limit;
            end
            for (i = blk + 1; i < stop && free_map[i]; i++) begin
                fwd++;
            end
            // The backward run ignores the block count and stops at block zero.
            for (i = blk; i > 0 && back < size && free_map[i - 1]; i--) begin
                back++;
            end
            merged = back + fwd + 1;
            if (merged > size) begin
                merged = size;
            end
            if (kind == KIND_FREE) begin
                run_count[merged] += 1;
                if (back > 0) run_count[back] -= 1;
                if (fwd > 0) run_count[fwd] -= 1;
            end else begin
                run_count[merged] -= 1;
                if (back > 0) run_count[back] += 1;
                if (fwd > 0) run_count[fwd] += 1;
            end
            o.res.forward_run  = RUN_W'(fwd);
            o.res.backward_run = RUN_W'(back);
            o.res.merged_class = RUN_W'(merged);
        end
        for (c = size; c > 0 && run_count[c] == 0; c--) begin
        end
        o.res.largest_class = RUN_W'(c);
        return o;
    endfunction

    task automatic flag(input string what, input int want, input int got);
        if (o_errors < 10) begin
            $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
        o_errors++;
    endtask

    always @(posedge i_clk) begin : watch
        t_outcome want;
        t_result  got;
        if (!i_rst_n) begin
            summary_reg = '0;
            count_reg   = COUNT_RESET;
            foreach (free_map[b]) free_map[b] = 1'b0;
            foreach (run_count[c]) run_count[c] = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_SUMMARY_SIZE) begin
                    summary_reg = i_cfg_data[SIZE_W-1:0];
                end else begin
                    count_reg = i_cfg_data;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[4*RUN_W-1:0];
                if (expected_results.size() == 0) begin
                    flag("unrequested result", 0, 1);
                end else begin
                    want = expected_results.pop_front();
                    if (got.forward_run != want.res.forward_run)
                        flag("forward_run", want.res.forward_run, got.forward_run);
                    if (got.backward_run != want.res.backward_run)
                        flag("backward_run", want.res.backward_run, got.backward_run);
                    if (got.merged_class != want.res.merged_class)
                        flag("merged_class", want.res.merged_class, got.merged_class);
                    if (got.largest_class != want.res.largest_class)
                        flag("largest_class", want.res.largest_class, got.largest_class);
                    if (i_m_tuser != want.oor)
                        flag("out_of_range", want.oor, i_m_tuser);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(account_request(i_s_tuser,
                                                           i_s_tdata[BLOCK_W-1:0]));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> sim/free_cluster_accounting_tb.sv
// Testbench top that drives requests and configuration into the block and gives the verdict.
module free_cluster_accounting_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fca_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    t_cfg_index           cfg_index;
    logic [COUNT_W-1:0]   cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    int                   pending;
    int                   errors;

    int eff_size;
    int eff_count;
    int burst_left;
    int free_pct;
    int quiet_cycles = 0;
    bit shadow_free [BITMAP_BLOCKS_DEF];
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;

    free_cluster_accounting i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    cluster_accounting_checker u_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : receiver
        int seg_left, stall_pct, k;
        m_tready  = 1'b0;
        seg_left  = 0;
        stall_pct = 0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                m_tready  = 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(5, 60);
                case ($urandom_range(0, 5))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 20;
                    3: stall_pct = 50;
                    4: stall_pct = 80;
                    default: stall_pct = 95;
                endcase
            end
            seg_left--;
            m_tready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic write_reg(input t_cfg_index idx, input int value);
        int v;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = COUNT_W'(value);
        if (idx == CFG_SUMMARY_SIZE) begin
            v = value & 31;
            eff_size = (v > MAX_SUMMARY_DEF) ? MAX_SUMMARY_DEF : v;
        end else begin
            v = value & 8191;
            eff_count = (v > BITMAP_BLOCKS_DEF) ? BITMAP_BLOCKS_DEF : v;
        end
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_request(input t_kind kind, input logic [BLOCK_W-1:0] blk);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = S_TDATA_W'(blk);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (eff_size != 0 && blk < eff_count) begin
            shadow_free[blk] = (kind == KIND_FREE);
        end
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    function automatic int window_base();
        int top_base;
        top_base = (eff_count > 48) ? eff_count - 48 : 0;
        case ($urandom_range(0, 3))
            0: return 0;
            1: return top_base;
            default: return $urandom_range(0, top_base);
        endcase
    endfunction

    // Most requests toggle a block inside a small window so that long free runs form;
    // the rest hit the ends of the range or anywhere, some of them with a random kind.
    task automatic pick_request(input int base, output t_kind kind,
                                output logic [BLOCK_W-1:0] blk);
        int r, tries;
        t_kind wanted;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            wanted = ($urandom_range(0, 99) < free_pct) ? KIND_FREE : KIND_ALLOC;
            tries = 0;
            do begin
                blk = BLOCK_W'(base + $urandom_range(0, 47));
                tries++;
            end while (tries < 8 && shadow_free[blk] == (wanted == KIND_FREE));
            kind = shadow_free[blk] ? KIND_ALLOC : KIND_FREE;
        end else begin
            if (r < 78) begin
                blk = BLOCK_W'(eff_count - 8 + $urandom_range(0, 15));
            end else if (r < 86) begin
                blk = BLOCK_W'($urandom_range(0, 24));
            end else begin
                blk = BLOCK_W'($urandom);
            end
            if ($urandom_range(0, 9) < 6) begin
                kind = shadow_free[blk] ? KIND_ALLOC : KIND_FREE;
            end else begin
                kind = t_kind'($urandom_range(0, 1));
            end
        end
    endtask

    initial begin : stimulus
        int base, n, k, done, phase, r;
        t_kind kind;
        logic [BLOCK_W-1:0] blk;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_SUMMARY_SIZE;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        eff_size   = 0;
        eff_count  = BITMAP_BLOCKS_DEF;
        burst_left = 0;
        free_pct   = 70;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Accounting is off after reset.
        send_request(KIND_FREE, 12'd5);
        send_request(KIND_ALLOC, 12'd4095);
        settle();
        write_reg(CFG_SUMMARY_SIZE, 16);
        write_reg(CFG_CLUSTER_BLOCK_COUNT, 4096);
        send_request(KIND_FREE, 12'd0);
        send_request(KIND_FREE, 12'd4095);
        send_request(KIND_FREE, 12'd1);
        send_request(KIND_FREE, 12'd3);
        send_request(KIND_FREE, 12'd2);
        send_request(KIND_ALLOC, 12'd2);
        send_request(KIND_FREE, 12'd2);
        send_request(KIND_ALLOC, 12'd0);
        send_request(KIND_ALLOC, 12'd4095);
        // Allocating a block that is already allocated drives a counter below zero.
        send_request(KIND_ALLOC, 12'd100);
        send_request(KIND_FREE, 12'd4094);
        settle();
        write_reg(CFG_CLUSTER_BLOCK_COUNT, 10);
        send_request(KIND_FREE, 12'd10);
        send_request(KIND_FREE, 12'd4095);
        send_request(KIND_FREE, 12'd9);
        send_request(KIND_FREE, 12'd8);
        send_request(KIND_ALLOC, 12'd9);
        settle();
        write_reg(CFG_SUMMARY_SIZE, 25);
        write_reg(CFG_CLUSTER_BLOCK_COUNT, 5000);
        send_request(KIND_FREE, 12'd4095);
        send_request(KIND_FREE, 12'd4093);
        settle();
        write_reg(CFG_SUMMARY_SIZE, 1);
        write_reg(CFG_CLUSTER_BLOCK_COUNT, 4096);
        send_request(KIND_FREE, 12'd50);
        send_request(KIND_FREE, 12'd51);
        settle();
        write_reg(CFG_CLUSTER_BLOCK_COUNT, 0);
        send_request(KIND_FREE, 12'd0);

        done  = 0;
        phase = 0;
        while (done < 1526) begin
            settle();
            case ($urandom_range(0, 7))
                0: r = 1;
                1: r = 16;
                2: r = $urandom_range(17, 31);
                3: r = 2;
                default: r = $urandom_range(1, 16);
            endcase
            if (phase > 2 && $urandom_range(0, 11) == 0) begin
                r = 0;
            end
            write_reg(CFG_SUMMARY_SIZE, ($urandom_range(0, 255) << SIZE_W) | r);
            case ($urandom_range(0, 9))
                0: r = 4096;
                1: r = $urandom_range(4097, 8191);
                2: r = 8191;
                3: r = $urandom_range(1, 64);
                4: r = (phase > 2) ? 0 : 4096;
                5: r = $urandom_range(4000, 4095);
                default: r = $urandom_range(65, 4095);
            endcase
            write_reg(CFG_CLUSTER_BLOCK_COUNT, r);
            free_pct = $urandom_range(50, 85);
            if (phase == 2) begin
                // The receiver holds off while requests keep coming back to back.
                hold_req   = 1'b1;
                burst_left = 300;
            end
            if (eff_size == 0) begin
                n = 8;
            end else if (eff_count == 0) begin
                n = 10;
            end else begin
                n = $urandom_range(60, 140);
            end
            base = window_base();
            for (k = 0; k < n; k++) begin
                if (k % 32 == 31 && $urandom_range(0, 1) == 1) begin
                    base = window_base();
                end
                pick_request(base, kind, blk);
                send_request(kind, blk);
                if (eff_size != 0) begin
                    done++;
                end
            end
            phase++;
        end

        settle();
        repeat (40) @(negedge clk);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
src/fca_pkg.sv
src/fca_front.sv
src/fca_queue.sv
src/fca_back.sv
src/free_cluster_accounting.sv
src/fca_checker.sv
sim/cluster_accounting_checker.sv
sim/free_cluster_accounting_tb.sv
